// File: design/toa_pkg.sv
`timescale 1ns / 1ps

package toa_pkg;

  localparam int unsigned PreStages  = 4;
  localparam int unsigned DivSteps   = 64;
  localparam int unsigned PostStages = 4;

  localparam logic [1:0] ModeAdd = 2'd0;
  localparam logic [1:0] ModeSub = 2'd1;
  localparam logic [1:0] ModeDiv = 2'd2;
  localparam logic [1:0] ModeRem = 2'd3;

  localparam logic [2:0] TagInt    = 3'd0;
  localparam logic [2:0] TagFloat  = 3'd1;
  localparam logic [2:0] TagString = 3'd2;
  localparam logic [2:0] TagList   = 3'd3;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StType = 2'd1;
  localparam logic [1:0] StDivz = 2'd2;
  localparam logic [1:0] StSoft = 2'd3;

  localparam logic [63:0] IntMin     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOnes    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DefaultNan = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;
  localparam logic [10:0] ExpMax     = 11'h7FF;

  typedef enum logic [2:0] {
    KindDone,
    KindIdiv,
    KindIrem,
    KindFdiv,
    KindFadd,
    KindFrnd
  } kind_e;

  // One in-flight transaction. The 64-bit words r, n and d change meaning from
  // stage to stage; n always holds the final result once kind is KindDone.
  typedef struct packed {
    kind_e              kind;
    logic [1:0]         st;
    logic               rtype;
    logic               neg;
    logic               eff_sub;
    logic signed [13:0] e1;
    logic signed [13:0] e2;
    logic [5:0]         la;
    logic [5:0]         lb;
    logic [63:0]        r;
    logic [63:0]        n;
    logic [63:0]        d;
  } pk_t;

  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] c;
    logic       found;
    c     = 7'd64;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && x[i]) begin
        c     = 7'(63 - i);
        found = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/toa_req_if.sv
`timescale 1ns / 1ps

interface toa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  lhs_type;
  logic [63:0] lhs_value;
  logic [2:0]  rhs_type;
  logic [63:0] rhs_value;

  modport source (output valid, mode, lhs_type, lhs_value, rhs_type, rhs_value,
                  input ready);
  modport sink (input valid, mode, lhs_type, lhs_value, rhs_type, rhs_value,
                output ready);
endinterface

// File: design/toa_rsp_if.sv
`timescale 1ns / 1ps

interface toa_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_type;
  logic [63:0] result_value;
  logic [1:0]  status;

  modport source (output valid, result_type, result_value, status, input ready);
  modport sink (input valid, result_type, result_value, status, output ready);
endinterface

// File: design/toa_div_pipe.sv
`timescale 1ns / 1ps

module toa_div_pipe (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  toa_pkg::pk_t pk_i,
  output logic         valid_o,
  input  logic         ready_i,
  output toa_pkg::pk_t pk_o
);
  import toa_pkg::*;

  logic v_q  [DivSteps];
  logic ld   [DivSteps];
  pk_t  pk_q [DivSteps];
  pk_t  pk_d [DivSteps];

  // One restoring step: the next dividend bit enters the remainder and the
  // quotient bit shifts into the freed low end of n.
  function automatic pk_t step_f(input pk_t p);
    pk_t         o;
    logic [64:0] rem2;
    logic        ge;
    o = p;
    if (p.kind == KindIdiv || p.kind == KindIrem || p.kind == KindFdiv) begin
      rem2   = {p.r, p.n[63]};
      ge     = rem2 >= {1'b0, p.d};
      rem2   = ge ? rem2 - {1'b0, p.d} : rem2;
      o.r    = rem2[63:0];
      o.n    = {p.n[62:0], ge};
    end
    return o;
  endfunction

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    if (i == DivSteps - 1) begin : g_last
      assign ld[i] = !v_q[i] || ready_i;
    end else begin : g_mid
      assign ld[i] = !v_q[i] || ld[i+1];
    end

    if (i == 0) begin : g_first
      assign pk_d[i] = step_f(pk_i);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[i] <= 1'b0;
        end else if (ld[i]) begin
          v_q[i] <= valid_i;
        end
      end
    end else begin : g_rest
      assign pk_d[i] = step_f(pk_q[i-1]);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[i] <= 1'b0;
        end else if (ld[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[i]) begin
        pk_q[i] <= pk_d[i];
      end
    end
  end

  assign ready_o = ld[0];
  assign valid_o = v_q[DivSteps-1];
  assign pk_o    = pk_q[DivSteps-1];

endmodule

// File: design/tagged_operand_alu_unit.sv
`timescale 1ns / 1ps
// Channel   Modport  Direction  Carries
// req_i     sink     in         mode, lhs_type, lhs_value, rhs_type, rhs_value
// rsp_o     source   out        result_type, result_value, status
//
// One transaction can be accepted every cycle unless the pipeline is full; results
// leave in the order their transactions were accepted.
// The depth is set by the 64-stage restoring divider shared by integer and double
// division; 4 stages before it decode, align and add; 4 after it normalize and round.
// Reset clears only the stage valid bits.
// A stalled output holds its result; empty stages behind it keep filling and
// req_i.ready drops only once no stage can move.

module tagged_operand_alu_unit (
  input logic     clk_i,
  input logic     rst_ni,
  toa_req_if.sink   req_i,
  toa_rsp_if.source rsp_o
);
  import toa_pkg::*;

  logic pre_v_q  [PreStages];
  logic pre_ld   [PreStages];
  pk_t  pre_q    [PreStages];
  pk_t  pre_d    [PreStages];
  logic post_v_q [PostStages];
  logic post_ld  [PostStages];
  pk_t  post_q   [PostStages];
  pk_t  post_d   [PostStages];
  pk_t  dec_pk;

  logic div_ready;
  logic div_valid;
  pk_t  div_pk;

  always_comb begin
    logic [63:0] a;
    logic [63:0] b;
    logic [10:0] ea;
    logic [10:0] eb;
    logic        sa;
    logic        sb;
    logic        sq;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    logic        int_pair;
    logic        flt_pair;
    pk_t         o;
    a        = req_i.lhs_value;
    b        = req_i.rhs_value;
    ea       = a[62:52];
    eb       = b[62:52];
    sa       = a[63];
    sb       = b[63] ^ (req_i.mode == ModeSub);
    sq       = a[63] ^ b[63];
    a_nan    = (ea == ExpMax) && (a[51:0] != '0);
    b_nan    = (eb == ExpMax) && (b[51:0] != '0);
    a_inf    = (ea == ExpMax) && (a[51:0] == '0);
    b_inf    = (eb == ExpMax) && (b[51:0] == '0);
    a_zero   = a[62:0] == '0;
    b_zero   = b[62:0] == '0;
    int_pair = (req_i.lhs_type == TagInt) && (req_i.rhs_type == TagInt);
    flt_pair = (req_i.lhs_type == TagFloat) && (req_i.rhs_type == TagFloat) &&
               (req_i.mode != ModeRem);
    o        = '0;
    o.kind   = KindDone;
    o.st     = StType;
    if (req_i.mode == ModeAdd && req_i.lhs_type == TagList) begin
      o.st = StSoft;
    end else if (int_pair) begin
      case (req_i.mode)
        ModeAdd: begin
          o.st = StOk;
          o.n  = a + b;
        end
        ModeSub: begin
          o.st = StOk;
          o.n  = a - b;
        end
        default: begin
          if (b == '0 || (a == IntMin && b == AllOnes)) begin
            o.st = StDivz;
          end else begin
            o.st   = StOk;
            o.kind = (req_i.mode == ModeDiv) ? KindIdiv : KindIrem;
            o.n    = a[63] ? -a : a;
            o.d    = b[63] ? -b : b;
            o.neg  = (req_i.mode == ModeDiv) ? sq : a[63];
          end
        end
      endcase
    end else if (flt_pair) begin
      o.st    = StOk;
      o.rtype = 1'b1;
      o.r     = {11'b0, (ea != '0), a[51:0]};
      o.d     = {11'b0, (eb != '0), b[51:0]};
      o.e1    = (ea == '0) ? 14'sd1 : $signed({3'b0, ea});
      o.e2    = (eb == '0) ? 14'sd1 : $signed({3'b0, eb});
      if (a_nan) begin
        o.n = a | QuietBit;
      end else if (b_nan) begin
        o.n = b | QuietBit;
      end else if (req_i.mode == ModeDiv) begin
        if ((a_inf && b_inf) || (a_zero && b_zero)) begin
          o.n = DefaultNan;
        end else if (a_inf || b_zero) begin
          o.n = {sq, ExpMax, 52'b0};
        end else if (a_zero || b_inf) begin
          o.n = {sq, 63'b0};
        end else begin
          o.kind = KindFdiv;
          o.neg  = sq;
        end
      end else begin
        if (a_inf && b_inf) begin
          o.n = (sa != sb) ? DefaultNan : {sa, ExpMax, 52'b0};
        end else if (a_inf) begin
          o.n = {sa, ExpMax, 52'b0};
        end else if (b_inf) begin
          o.n = {sb, ExpMax, 52'b0};
        end else if (a_zero && b_zero) begin
          o.n = {sa & sb, 63'b0};
        end else if (a_zero) begin
          o.n = {sb, b[62:0]};
        end else if (b_zero) begin
          o.n = a;
        end else begin
          o.kind    = KindFadd;
          o.neg     = sa;
          o.eff_sub = sa ^ sb;
        end
      end
    end else if (req_i.mode == ModeAdd && req_i.lhs_type == TagString &&
                 req_i.rhs_type == TagString) begin
      o.st = StSoft;
    end
    dec_pk = o;
  end

  // Divide: leading-zero counts of both mantissas. Add: order the operands by
  // magnitude and work out the alignment distance.
  function automatic pk_t s2_f(input pk_t p);
    pk_t                o;
    logic [6:0]         za;
    logic [6:0]         zb;
    logic               a_big;
    logic signed [13:0] diff;
    o     = p;
    za    = lzc64({p.r[52:0], 11'b0});
    zb    = lzc64({p.d[52:0], 11'b0});
    a_big = (p.e1 > p.e2) || (p.e1 == p.e2 && p.r >= p.d);
    diff  = a_big ? p.e1 - p.e2 : p.e2 - p.e1;
    if (p.kind == KindFdiv) begin
      o.la = za[5:0];
      o.lb = zb[5:0];
    end else if (p.kind == KindFadd) begin
      o.la = (diff > 14'sd63) ? 6'd63 : diff[5:0];
      if (!a_big) begin
        o.r   = p.d;
        o.d   = p.r;
        o.e1  = p.e2;
        o.neg = p.neg ^ p.eff_sub;
      end
    end
    return o;
  endfunction

  function automatic pk_t s3_f(input pk_t p);
    pk_t         o;
    logic [52:0] man;
    logic [52:0] mbn;
    logic [63:0] y;
    logic [63:0] ys;
    logic [63:0] mask;
    o    = p;
    man  = p.r[52:0] << p.la;
    mbn  = p.d[52:0] << p.lb;
    y    = {1'b0, p.d[52:0], 10'b0};
    ys   = y >> p.la;
    mask = (64'd1 << p.la) - 64'd1;
    if (p.kind == KindFdiv) begin
      o.e1 = (p.e1 - $signed({8'b0, p.la})) - (p.e2 - $signed({8'b0, p.lb}));
      o.r  = {11'b0, man};
      o.d  = {10'b0, mbn, 1'b0};
      o.n  = '0;
    end else if (p.kind == KindFadd) begin
      o.r = {1'b0, p.r[52:0], 10'b0};
      o.d = {ys[63:1], ys[0] | ((y & mask) != '0)};
    end
    return o;
  endfunction

  function automatic pk_t s4_f(input pk_t p);
    pk_t o;
    o = p;
    if (p.kind == KindFadd) begin
      o.n = p.eff_sub ? p.r - p.d : p.r + p.d;
    end
    return o;
  endfunction

  function automatic pk_t p1_f(input pk_t p);
    pk_t        o;
    logic [6:0] z;
    o = p;
    z = lzc64(p.n);
    case (p.kind)
      KindIdiv: begin
        o.n    = p.neg ? -p.n : p.n;
        o.kind = KindDone;
      end
      KindIrem: begin
        o.n    = p.neg ? -p.r : p.r;
        o.kind = KindDone;
      end
      KindFdiv: begin
        if (p.n[63]) begin
          o.n  = {p.n[63:1], p.n[0] | (p.r != '0)};
          o.e1 = p.e1 + 14'sd1023;
        end else begin
          o.n  = {p.n[62:0], p.r != '0};
          o.e1 = p.e1 + 14'sd1022;
        end
        o.kind = KindFrnd;
      end
      KindFadd: begin
        if (p.n == '0) begin
          o.kind = KindDone;
        end else begin
          o.la = z[5:0];
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic pk_t p2_f(input pk_t p);
    pk_t o;
    o = p;
    if (p.kind == KindFadd) begin
      o.n    = p.n << p.la;
      o.e1   = p.e1 + 14'sd1 - $signed({8'b0, p.la});
      o.kind = KindFrnd;
    end
    return o;
  endfunction

  // Results below the normal range shift right into subnormal position.
  function automatic pk_t p3_f(input pk_t p);
    pk_t                o;
    logic signed [13:0] sh;
    logic [5:0]         shc;
    logic [63:0]        mask;
    o    = p;
    sh   = 14'sd1 - p.e1;
    shc  = (sh > 14'sd63) ? 6'd63 : sh[5:0];
    mask = (64'd1 << shc) - 64'd1;
    if (p.kind == KindFrnd && p.e1 < 14'sd1) begin
      o.n  = (p.n >> shc) | {63'b0, (p.n & mask) != '0};
      o.e1 = '0;
    end
    return o;
  endfunction

  // Round to nearest even; a carry out of the fraction bumps the exponent.
  function automatic pk_t p4_f(input pk_t p);
    pk_t         o;
    logic        up;
    logic [62:0] body;
    o    = p;
    up   = p.n[10] && ((p.n[9:0] != '0) || p.n[11]);
    body = {p.e1[10:0], p.n[62:11]} + {62'b0, up};
    if (p.kind == KindFrnd) begin
      o.kind = KindDone;
      if (p.e1 >= 14'sd2047) begin
        o.n = {p.neg, ExpMax, 52'b0};
      end else begin
        o.n = {p.neg, body};
      end
    end
    return o;
  endfunction

  assign pre_d[0] = dec_pk;
  assign pre_d[1] = s2_f(pre_q[0]);
  assign pre_d[2] = s3_f(pre_q[1]);
  assign pre_d[3] = s4_f(pre_q[2]);

  assign post_d[0] = p1_f(div_pk);
  assign post_d[1] = p2_f(post_q[0]);
  assign post_d[2] = p3_f(post_q[1]);
  assign post_d[3] = p4_f(post_q[2]);

  for (genvar i = 0; i < PreStages; i++) begin : g_pre
    if (i == PreStages - 1) begin : g_last
      assign pre_ld[i] = !pre_v_q[i] || div_ready;
    end else begin : g_mid
      assign pre_ld[i] = !pre_v_q[i] || pre_ld[i+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pre_v_q[i] <= 1'b0;
      end else if (pre_ld[i]) begin
        pre_v_q[i] <= (i == 0) ? req_i.valid : pre_v_q[(i == 0) ? 0 : i - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (pre_ld[i]) begin
        pre_q[i] <= pre_d[i];
      end
    end
  end

  toa_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(pre_v_q[PreStages-1]),
    .ready_o(div_ready),
    .pk_i   (pre_q[PreStages-1]),
    .valid_o(div_valid),
    .ready_i(post_ld[0]),
    .pk_o   (div_pk)
  );

  for (genvar i = 0; i < PostStages; i++) begin : g_post
    if (i == PostStages - 1) begin : g_last
      assign post_ld[i] = !post_v_q[i] || rsp_o.ready;
    end else begin : g_mid
      assign post_ld[i] = !post_v_q[i] || post_ld[i+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        post_v_q[i] <= 1'b0;
      end else if (post_ld[i]) begin
        post_v_q[i] <= (i == 0) ? div_valid : post_v_q[(i == 0) ? 0 : i - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (post_ld[i]) begin
        post_q[i] <= post_d[i];
      end
    end
  end

  assign req_i.ready        = pre_ld[0];
  assign rsp_o.valid        = post_v_q[PostStages-1];
  assign rsp_o.result_type  = post_q[PostStages-1].rtype;
  assign rsp_o.result_value = post_q[PostStages-1].n;
  assign rsp_o.status       = post_q[PostStages-1].st;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> post_q[PostStages-1].kind == KindDone)
    else $error("A transaction reached the output before its result was complete.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != StOk |->
      rsp_o.result_value == '0 && !rsp_o.result_type)
    else $error("A failed transaction carries a nonzero result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pre_v_q[0] && (pre_q[0].kind == KindIdiv || pre_q[0].kind == KindIrem) |->
      pre_q[0].d != '0)
    else $error("An integer division by zero entered the divider.");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import toa_pkg::*;

  localparam logic [2:0] TagOther = 3'd4;
  localparam logic [63:0] PosInf = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NegInf = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] DblOne = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DblNegZero = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        rtype;
    logic [63:0] value;
    logic [1:0]  st;
  } alu_result_t;

  logic clk_i;
  logic rst_ni;

  toa_req_if req ();
  toa_rsp_if rsp ();

  tagged_operand_alu_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  alu_result_t pending_results[$];
  int          mismatches;
  int          src_gap_pct;
  int          snk_gap_pct;
  int          hold_cycles;

  initial begin
    req.valid     = 1'b0;
    req.mode      = ModeAdd;
    req.lhs_type  = TagInt;
    req.lhs_value = '0;
    req.rhs_type  = TagInt;
    req.rhs_value = '0;
    rsp.ready     = 1'b0;
  end

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic alu_result_t alu_predict(logic [1:0] mode, logic [2:0] lt,
                                              logic [63:0] a, logic [2:0] rt,
                                              logic [63:0] b);
    alu_result_t res;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    real x;
    real y;
    res = '{rtype: 1'b0, value: '0, st: StType};
    sa = a;
    sb = b;
    x = $bitstoreal(a);
    y = $bitstoreal(b);
    if (mode == ModeAdd && lt == TagList) begin
      res.st = StSoft;
    end else if (lt == TagInt && rt == TagInt) begin
      if ((mode == ModeDiv || mode == ModeRem) && (b == '0 || (a == IntMin && b == AllOnes))) begin
        res.st = StDivz;
      end else begin
        res.st = StOk;
        case (mode)
          ModeAdd: res.value = a + b;
          ModeSub: res.value = a - b;
          ModeDiv: res.value = sa / sb;
          default: res.value = sa % sb;
        endcase
      end
    end else if (lt == TagFloat && rt == TagFloat && mode != ModeRem) begin
      res.st    = StOk;
      res.rtype = 1'b1;
      case (mode)
        ModeAdd: res.value = $realtobits(x + y);
        ModeSub: res.value = $realtobits(x - y);
        default: res.value = $realtobits(x / y);
      endcase
    end else if (mode == ModeAdd && lt == TagString && rt == TagString) begin
      res.st = StSoft;
    end
    return res;
  endfunction

  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    $display("mismatch on %s: expected %h, got %h at %0t", field, want, got, $time);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t want;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected transaction", '0, rsp.result_value);
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.st) report("status", 64'(want.st), 64'(rsp.status));
          if (rsp.result_type !== want.rtype)
            report("result_type", 64'(want.rtype), 64'(rsp.result_type));
          if (rsp.result_value !== want.value) report("result_value", want.value, rsp.result_value);
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= snk_gap_pct);
      end
    end
  end

  task automatic send_op(logic [1:0] mode, logic [2:0] lt, logic [63:0] a,
                         logic [2:0] rt, logic [63:0] b);
    if ($urandom_range(99) < src_gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.mode      <= mode;
    req.lhs_type  <= lt;
    req.lhs_value <= a;
    req.rhs_type  <= rt;
    req.rhs_value <= b;
    do @(posedge clk_i); while (!req.ready);
    pending_results.insert(pending_results.size(), alu_predict(mode, lt, a, rt, b));
  endtask

  task automatic stop_sending();
    req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_int();
    case ($urandom_range(7))
      0: return IntMin;
      1: return AllOnes;
      2: return '0;
      3: return 64'(signed'($urandom_range(40)) - 20);
      4: return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] rand_dbl();
    logic s;
    s = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: return {s, 63'd0};
      1: return {s, ExpMax, 52'd0};
      2: return {s, ExpMax, 1'b1, 51'($urandom)};
      3: return {s, ExpMax, 1'b0, 51'($urandom | 1)};
      4: return {s, 11'd0, 20'($urandom), $urandom};
      5: return {s, 11'h7FE, 20'($urandom), $urandom};
      6: return {s, 11'($urandom_range(1080, 970)), 20'($urandom), $urandom};
      7: return {s, 11'($urandom_range(1, 3)), 20'($urandom), $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] lt;
    logic [2:0] rt;
    logic [1:0] mode;
    int pick;
    mode = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_op(mode, TagInt, rand_int(), TagInt, rand_int());
    end else if (pick < 85) begin
      send_op(mode, TagFloat, rand_dbl(), TagFloat, rand_dbl());
    end else begin
      lt = 3'($urandom_range(7));
      rt = 3'($urandom_range(7));
      send_op(mode, lt, {$urandom, $urandom}, rt, {$urandom, $urandom});
    end
  endtask

  task automatic test_directed();
    send_op(ModeAdd, TagInt, 64'h7FFF_FFFF_FFFF_FFFF, TagInt, 64'd1);
    send_op(ModeSub, TagInt, IntMin, TagInt, 64'd1);
    send_op(ModeDiv, TagInt, 64'd7, TagInt, AllOnes - 1);
    send_op(ModeRem, TagInt, AllOnes - 6, TagInt, 64'd2);
    send_op(ModeDiv, TagInt, 64'd5, TagInt, '0);
    send_op(ModeRem, TagInt, 64'd5, TagInt, '0);
    send_op(ModeDiv, TagInt, IntMin, TagInt, AllOnes);
    send_op(ModeRem, TagInt, IntMin, TagInt, AllOnes);
    send_op(ModeAdd, TagInt, AllOnes, TagInt, AllOnes);
    send_op(ModeAdd, TagFloat, DblOne, TagFloat, DblOne);
    send_op(ModeSub, TagFloat, DblOne, TagFloat, DblNegZero);
    send_op(ModeDiv, TagFloat, DblOne, TagFloat, '0);
    send_op(ModeDiv, TagFloat, '0, TagFloat, '0);
    send_op(ModeSub, TagFloat, PosInf, TagFloat, PosInf);
    send_op(ModeAdd, TagFloat, NegInf, TagFloat, DefaultNan | 64'h1234);
    send_op(ModeAdd, TagFloat, 64'h7FEF_FFFF_FFFF_FFFF, TagFloat, 64'h7FEF_FFFF_FFFF_FFFF);
    send_op(ModeRem, TagFloat, DblOne, TagFloat, DblOne);
    send_op(ModeAdd, TagList, '0, TagOther, AllOnes);
    send_op(ModeAdd, TagString, '0, TagString, '0);
    send_op(ModeSub, TagString, '0, TagString, '0);
    send_op(ModeAdd, TagInt, DblOne, TagFloat, DblOne);
    send_op(ModeSub, TagList, '0, TagList, '0);
    send_op(ModeAdd, 3'd7, AllOnes, 3'd7, AllOnes);
    send_op(ModeDiv, TagFloat, 64'h0000_0000_0000_0001, TagFloat, 64'h4000_0000_0000_0000);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random(int count, int src_pct, int snk_pct);
    src_gap_pct = src_pct;
    snk_gap_pct = snk_pct;
    repeat (count) send_random();
    stop_sending();
  endtask

  task automatic test_backpressure();
    src_gap_pct = 0;
    snk_gap_pct = 0;
    hold_cycles = 300;
    repeat (150) send_random();
    stop_sending();
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (40) send_random();
    stop_sending();
    wait_drained();
    repeat (40) send_random();
    stop_sending();
  endtask

  initial begin
    mismatches  = 0;
    src_gap_pct = 0;
    snk_gap_pct = 0;
    hold_cycles = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450, 18, 51);
    test_random(450, 51, 18);
    test_random(400, 0, 0);
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
design/toa_pkg.sv
design/toa_req_if.sv
design/toa_rsp_if.sv
design/toa_div_pipe.sv
design/tagged_operand_alu_unit.sv
tb/sv/tb_top.sv
